>>> hdl/kue_pkg.sv
// shared types and constants for the 8-bit accumulator cpu step block
// no dependencies
package kue_pkg;

  typedef struct packed {
    logic [1:0] req_type;
    logic [8:0] mem_addr;
    logic [7:0] data_byte;
  } kue_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] prog_counter;
    logic [7:0] accumulator;
    logic [7:0] index_reg;
    logic       carry_flag;
    logic       overflow_flag;
    logic       negative_flag;
    logic       zero_flag;
    logic [7:0] out_byte;
    logic       out_full;
    logic       in_full;
  } kue_out_t;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_IN    = 2'd2;
  localparam logic [1:0] REQ_ACK   = 2'd3;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_HLT  = 2'd1;
  localparam logic [1:0] ST_UNK  = 2'd2;
  localparam logic [1:0] ST_BADS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_OPC, S_SEC, S_OPND, S_DONE, S_OUT
  } kue_state_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;   // latch item and start
    logic [1:0] mem_rd;   // 0 none, 1 opcode, 2 second byte, 3 operand
    logic       finish;   // apply instruction / simple request
    logic       out_load;
  } kue_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_exec;
    logic need_sec;
    logic need_opnd;
  } kue_sts_t;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_OPC  = 2'd1;
  localparam logic [1:0] RD_SEC  = 2'd2;
  localparam logic [1:0] RD_OPND = 2'd3;

endpackage

>>> hdl/kue_ctrl.sv
// controller state machine for the cpu step block
// depends on kue_pkg
module kue_ctrl import kue_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  kue_sts_t sts,
  output kue_cmd_t cmd
);

  kue_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_OPC;
        end
      end
      S_OPC: begin
        if (sts.is_exec) begin
          cmd.mem_rd = RD_OPC;
          state_nxt = S_SEC;
        end else state_nxt = S_DONE;
      end
      S_SEC: begin
        if (sts.need_sec) begin
          cmd.mem_rd = RD_SEC;
          state_nxt = S_OPND;
        end else state_nxt = S_DONE;
      end
      S_OPND: begin
        if (sts.need_opnd) cmd.mem_rd = RD_OPND;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> state_r == S_OUT)
    else $error("result not presented after finish");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall)
    else $error("input taken while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_stall |=> state_r == S_OUT)
    else $error("stalled result dropped");

endmodule

>>> hdl/kue_dp.sv
// datapath: memory, registers, alu and result register
// depends on kue_pkg
module kue_dp import kue_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  kue_in_t  in_data,
  input  kue_cmd_t cmd,
  output kue_sts_t sts,
  output kue_out_t out_data
);

  logic [7:0] mem [512];
  logic [7:0] rdata;
  logic [8:0] raddr;

  kue_in_t  req_r;
  logic [7:0] ir_r, d_r, opnd_r;
  logic [7:0] pc_r, acc_r, ix_r, inb_r, outb_r;
  logic       cf_r, vf_r, nf_r, zf_r, inf_r, outf_r;
  logic [1:0] rd_r;
  kue_out_t   res_r;

  // opcode straight from the memory in the cycle after its read
  logic [7:0] op;
  assign op = (rd_r == RD_OPC) ? rdata : ir_r;

  logic [3:0] hi;
  logic [2:0] md;
  logic       sel;
  assign hi  = op[7:4];
  assign md  = op[2:0];
  assign sel = op[3];

  logic [7:0] ixd;
  assign ixd = ix_r + rdata;

  always_comb begin
    case (md)
      3'd4:    raddr = {1'b0, rdata};
      3'd5:    raddr = {1'b1, rdata};
      3'd6:    raddr = {1'b0, ixd};
      default: raddr = {1'b1, ixd};
    endcase
  end

  logic [8:0] mem_ra;
  always_comb begin
    case (cmd.mem_rd)
      RD_OPC:  mem_ra = {1'b0, pc_r};
      RD_SEC:  mem_ra = {1'b0, pc_r + 8'd1};
      RD_OPND: mem_ra = raddr;
      default: mem_ra = {1'b0, pc_r};
    endcase
  end

  logic do_wr;
  logic [8:0] wa;
  logic [7:0] wd;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wa] <= wd;
    rdata <= mem[mem_ra];
  end

  // operand fetch decode
  logic uses_b, is_st;
  always_comb begin
    uses_b = (hi == 4'h6) || (hi >= 4'h8);
    is_st  = (hi == 4'h7);
    sts.is_exec   = (req_r.req_type == REQ_EXEC);
    sts.need_sec  = (hi == 4'h3) || is_st || (op == 8'h0a) ||
                    (uses_b && md[2:1] != 2'b00);
    sts.need_opnd = uses_b && md[2];
  end

  logic [7:0] a, b;
  logic [8:0] pc_len;
  always_comb begin
    a = sel ? ix_r : acc_r;
    case (md)
      3'd0:    b = acc_r;
      3'd1:    b = ix_r;
      3'd2,
      3'd3:    b = d_r;
      default: b = (rd_r == RD_OPND) ? rdata : opnd_r;
    endcase
  end

  logic lt, tk;
  always_comb begin
    lt = vf_r ^ nf_r;
    case (ir_r[3:0])
      4'd0:  tk = 1'b1;
      4'd1:  tk = !zf_r;
      4'd2:  tk = !nf_r;
      4'd3:  tk = !(nf_r || zf_r);
      4'd4:  tk = !inf_r;
      4'd5:  tk = !cf_r;
      4'd6:  tk = !lt;
      4'd7:  tk = !(lt || zf_r);
      4'd8:  tk = vf_r;
      4'd9:  tk = zf_r;
      4'd10: tk = nf_r;
      4'd11: tk = nf_r || zf_r;
      4'd12: tk = outf_r;
      4'd13: tk = cf_r;
      4'd14: tk = lt;
      default: tk = lt || zf_r;
    endcase
  end

  function automatic logic [8:0] raddr_st(input logic [2:0] m, input logic [7:0] x,
                                          input logic [7:0] d);
    logic [7:0] s;
    s = x + d;
    case (m)
      3'd4:    raddr_st = {1'b0, d};
      3'd5:    raddr_st = {1'b1, d};
      3'd6:    raddr_st = {1'b0, s};
      default: raddr_st = {1'b1, s};
    endcase
  endfunction

  logic [7:0] pc_n, acc_n, ix_n, inb_n, outb_n, r, pcp;
  logic       cf_n, vf_n, nf_n, zf_n, inf_n, outf_n, wa_en, setf, cn, vn;
  logic [8:0] sum;
  logic [1:0] st;
  logic       top, low;
  always_comb begin
    pc_n = pc_r; acc_n = acc_r; ix_n = ix_r; inb_n = inb_r; outb_n = outb_r;
    cf_n = cf_r; vf_n = vf_r; nf_n = nf_r; zf_n = zf_r;
    inf_n = inf_r; outf_n = outf_r;
    do_wr = 1'b0; wa = req_r.mem_addr; wd = req_r.data_byte;
    st = ST_RUN; wa_en = 1'b0; setf = 1'b0; r = 8'd0; cn = cf_r; vn = 1'b0;
    sum = 9'd0; top = 1'b0; low = 1'b0;
    pc_len = {1'b0, pc_r} + 9'd1 + {8'd0, sts.need_sec};
    pcp = pc_len[7:0];
    pc_len = 9'd0;
    if (cmd.finish) begin
      case (req_r.req_type)
        REQ_WRITE: do_wr = 1'b1;
        REQ_IN: begin
          inb_n = req_r.data_byte; inf_n = 1'b1;
        end
        REQ_ACK: outf_n = 1'b0;
        default: begin
          pc_n = pcp;
          case (hi)
            4'h0: begin
              if (ir_r >= 8'h0c) st = ST_HLT;
              else if (ir_r == 8'h0a) begin
                acc_n = pcp; pc_n = d_r;
              end else if (ir_r == 8'h0b) pc_n = acc_r;
              else if (ir_r == 8'h08 || ir_r == 8'h09) st = ST_UNK;
            end
            4'h1: begin
              if (ir_r[3]) begin
                acc_n = inb_r; inf_n = 1'b0;
              end else begin
                outb_n = acc_r; outf_n = 1'b1;
              end
            end
            4'h2: cf_n = ir_r[3];
            4'h3: if (tk) pc_n = d_r;
            4'h4: begin
              if (!md[0]) begin
                case (md)
                  3'd0:    top = a[7];
                  3'd2:    top = 1'b0;
                  3'd4:    top = cf_r;
                  default: top = a[0];
                endcase
                r = {top, a[7:1]}; cn = a[0];
              end else begin
                case (md)
                  3'd1, 3'd3: low = 1'b0;
                  3'd5:       low = cf_r;
                  default:    low = a[7];
                endcase
                r = {a[6:0], low}; cn = a[7];
                if (md == 3'd1 || md == 3'd5) vn = a[7] ^ r[7];
              end
              setf = 1'b1; wa_en = 1'b1;
            end
            4'h6: begin
              r = b; wa_en = 1'b1;
            end
            4'h7: begin
              if (!md[2]) st = ST_BADS;
              else begin
                do_wr = 1'b1; wa = raddr_st(md, ix_r, d_r); wd = a;
              end
            end
            4'h8: begin
              sum = {1'b0, a} - {1'b0, b} - {8'd0, cf_r};
              r = sum[7:0]; cn = sum[8];
              vn = (a[7] ^ b[7]) & (a[7] ^ r[7]);
              setf = 1'b1; wa_en = 1'b1;
            end
            4'h9: begin
              sum = {1'b0, a} + {1'b0, b} + {8'd0, cf_r};
              r = sum[7:0]; cn = sum[8];
              vn = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
              setf = 1'b1; wa_en = 1'b1;
            end
            4'ha, 4'hf: begin
              sum = {1'b0, a} - {1'b0, b};
              r = sum[7:0];
              vn = (a[7] ^ b[7]) & (a[7] ^ r[7]);
              setf = 1'b1; wa_en = (hi == 4'ha);
            end
            4'hb: begin
              sum = {1'b0, a} + {1'b0, b};
              r = sum[7:0];
              vn = (~(a[7] ^ b[7]) & (a[7] ^ r[7])) | sum[8];
              setf = 1'b1; wa_en = 1'b1;
            end
            4'hc, 4'hd, 4'he: begin
              if (hi == 4'hc) r = a ^ b;
              else if (hi == 4'hd) r = a | b;
              else r = a & b;
              setf = 1'b1; wa_en = 1'b1;
            end
            default: st = ST_UNK;
          endcase
          if (setf) begin
            cf_n = cn; vf_n = vn; nf_n = r[7]; zf_n = (r == 8'd0);
          end
          if (wa_en) begin
            if (sel) ix_n = r;
            else acc_n = r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) req_r <= in_data;
    rd_r <= cmd.mem_rd;
    case (rd_r)
      RD_OPC:  ir_r <= rdata;
      RD_SEC:  d_r <= rdata;
      RD_OPND: opnd_r <= rdata;
      default: ;
    endcase
    if (cmd.accept) ir_r <= 8'h00;
    if (cmd.out_load) begin
      res_r.status        <= st;
      res_r.prog_counter  <= pc_n;
      res_r.accumulator   <= acc_n;
      res_r.index_reg     <= ix_n;
      res_r.carry_flag    <= cf_n;
      res_r.overflow_flag <= vf_n;
      res_r.negative_flag <= nf_n;
      res_r.zero_flag     <= zf_n;
      res_r.out_byte      <= outb_n;
      res_r.out_full      <= outf_n;
      res_r.in_full       <= inf_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; acc_r <= '0; ix_r <= '0; inb_r <= '0; outb_r <= '0;
      cf_r <= 1'b0; vf_r <= 1'b0; nf_r <= 1'b0; zf_r <= 1'b0;
      inf_r <= 1'b0; outf_r <= 1'b0;
    end else if (cmd.finish) begin
      pc_r <= pc_n; acc_r <= acc_n; ix_r <= ix_n; inb_r <= inb_n;
      outb_r <= outb_n; cf_r <= cf_n; vf_r <= vf_n; nf_r <= nf_n;
      zf_r <= zf_n; inf_r <= inf_n; outf_r <= outf_n;
    end
  end

  assign out_data = res_r;

  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> $stable(pc_r))
    else $error("pc changed outside finish");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr |-> cmd.finish)
    else $error("memory write outside finish");
  a_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> cmd.mem_rd == RD_NONE)
    else $error("read during finish");

endmodule

>>> hdl/eight_bit_cpu_instruction_step_top.sv
// top level of the 8-bit accumulator cpu step block
// depends on kue_pkg, kue_ctrl, kue_dp
//
// input channel in_valid/in_stall/in_data carries one request per beat:
// write a memory byte, execute one instruction, deliver an input byte,
// or acknowledge the output port. each accepted beat produces exactly one
// result beat on out_valid/out_stall/out_data with the status and the full
// register, flag and port state after the request.
// one request is handled at a time: an execute beat goes through the
// opcode read, then the second byte read and the operand read from memory
// when the instruction needs them, then apply and present; other requests
// only apply and present. the next beat is taken the cycle after the
// result is taken.
// while the receiver stalls the result is held steady and no new input is
// taken. reset clears pc, acc, ix, flags and both ports; memory contents
// are undefined until written, so programs must store before loading.
module eight_bit_cpu_instruction_step_top import kue_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  kue_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output kue_out_t out_data
);

  kue_cmd_t cmd;
  kue_sts_t sts;

  kue_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  kue_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );

endmodule
